// ===== rtl/core/minmax_display_decimator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the min/max display decimator
// Clocked property checks used by mmdd_core, the RTL file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef MINMAX_DISPLAY_DECIMATOR_MACROS_SVH
`define MINMAX_DISPLAY_DECIMATOR_MACROS_SVH

// check on every clock edge outside reset
`define MMDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define MMDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/mmdd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmdd_pkg
// Widths, register codes and payload types of the min/max display decimator.
// ----------------------------------------------------------------------------
package mmdd_pkg;

  localparam int unsigned POS_BITS      = 32;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned WIDTH_BITS    = 13;
  localparam int unsigned SPAN_BITS     = 32;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam int unsigned PROD_BITS = POS_BITS + WIDTH_BITS;
  localparam int unsigned CMP_BITS  = (PROD_BITS > SPAN_BITS) ? PROD_BITS : SPAN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_SPAN  = 1'b1;

  localparam logic [WIDTH_BITS-1:0] VIEW_WIDTH_RST = WIDTH_BITS'(1024);
  localparam logic [SPAN_BITS-1:0]  VIEW_SPAN_RST  = SPAN_BITS'(1024);

  typedef struct packed {
    logic [WIDTH_BITS-1:0] view_width_px;
    logic [SPAN_BITS-1:0]  view_span;
  } cfg_t;

  typedef struct packed {
    logic                          frame_start;
    logic [POS_BITS-1:0]           x_pos;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]           point_x;
    logic signed [SAMPLE_BITS-1:0] y_max;
    logic signed [SAMPLE_BITS-1:0] y_min;
  } result_t;

endpackage

// ===== rtl/core/mmdd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mmdd_cfg_regs
// View width and span registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module mmdd_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mmdd_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [mmdd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output mmdd_pkg::cfg_t                       cfg_o
);

  logic [mmdd_pkg::WIDTH_BITS-1:0] width_q;
  logic [mmdd_pkg::SPAN_BITS-1:0]  span_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mmdd_pkg::VIEW_WIDTH_RST;
      span_q  <= mmdd_pkg::VIEW_SPAN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mmdd_pkg::CFG_VIEW_WIDTH: width_q <= cfg_data_i[mmdd_pkg::WIDTH_BITS-1:0];
        mmdd_pkg::CFG_VIEW_SPAN:  span_q  <= cfg_data_i[mmdd_pkg::SPAN_BITS-1:0];
        default:                  span_q  <= span_q;
      endcase
    end
  end

  assign cfg_o.view_width_px = width_q;
  assign cfg_o.view_span     = span_q;

endmodule

// ===== rtl/core/mmdd_in_reg.sv =====
// ----------------------------------------------------------------------------
// mmdd_in_reg
// Input register: holds one sample request until the core takes it.
// ----------------------------------------------------------------------------
module mmdd_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mmdd_pkg::item_t     item_i,
  output logic                valid_o,
  output mmdd_pkg::item_t     item_o,
  input  logic                pop_i
);

  logic            valid_q, valid_d;
  mmdd_pkg::item_t item_q;
  logic            load;

  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/mmdd_core.sv =====
// ----------------------------------------------------------------------------
// mmdd_core
// Pixel distance test, min/max group tracking and result register.
// ----------------------------------------------------------------------------
`include "minmax_display_decimator_macros.svh"

module mmdd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmdd_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  input  mmdd_pkg::item_t     item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mmdd_pkg::result_t   result_o
);

  logic                                    have_prev_q, have_prev_d;
  logic                                    group_open_q, group_open_d;
  logic [mmdd_pkg::POS_BITS-1:0]           prev_x_q;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] prev_y_q;
  logic [mmdd_pkg::POS_BITS-1:0]           group_x_q, group_x_d;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] group_max_q, group_max_d;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] group_min_q, group_min_d;
  logic                                    out_valid_q, out_valid_d;
  mmdd_pkg::result_t                       result_q, result_d;

  logic                                    adv, hp, go, wide, emit, ge;
  logic [mmdd_pkg::POS_BITS-1:0]           dx;
  logic [mmdd_pkg::CMP_BITS-1:0]           prod;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] y;

  assign adv = valid_i && (!out_valid_q || out_ready_i);
  assign y   = item_i.sample;
  assign hp  = have_prev_q && !item_i.frame_start;
  assign go  = group_open_q && !item_i.frame_start;
  assign ge  = item_i.x_pos >= prev_x_q;
  assign dx  = item_i.x_pos - prev_x_q;

  assign prod = mmdd_pkg::CMP_BITS'(dx) * mmdd_pkg::CMP_BITS'(cfg_i.view_width_px);
  assign wide = hp && ge && (prod > mmdd_pkg::CMP_BITS'(cfg_i.view_span));
  assign emit = adv && wide;

  always_comb begin
    have_prev_d  = have_prev_q;
    group_open_d = group_open_q;
    group_x_d    = group_x_q;
    group_max_d  = group_max_q;
    group_min_d  = group_min_q;
    result_d     = result_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (adv) begin
      have_prev_d  = 1'b1;
      group_open_d = go;
      if (wide) begin
        group_open_d = 1'b0;
        out_valid_d  = 1'b1;
        if (go) begin
          result_d.point_x = group_x_q;
          result_d.y_max   = group_max_q;
          result_d.y_min   = group_min_q;
        end else begin
          result_d.point_x = prev_x_q;
          result_d.y_max   = prev_y_q;
          result_d.y_min   = prev_y_q;
        end
      end else if (hp && !go) begin
        group_open_d = 1'b1;
        group_x_d    = prev_x_q;
        group_max_d  = (prev_y_q > y) ? prev_y_q : y;
        group_min_d  = (prev_y_q > y) ? y : prev_y_q;
      end else if (hp) begin
        if (y > group_max_q) begin
          group_max_d = y;
        end
        if (y < group_min_q) begin
          group_min_d = y;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      group_open_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      have_prev_q  <= have_prev_d;
      group_open_q <= group_open_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prev_x_q <= item_i.x_pos;
      prev_y_q <= y;
    end
    group_x_q   <= group_x_d;
    group_max_q <= group_max_d;
    group_min_q <= group_min_d;
    result_q    <= result_d;
  end

  assign pop_o       = adv;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `MMDD_ASSERT_ALWAYS(a_group_needs_prev, group_open_q |-> have_prev_q, "group open without previous sample")
  `MMDD_ASSERT(a_group_ordered, group_open_q |-> (group_min_q <= group_max_q), "group min above max")
  `MMDD_ASSERT(a_result_ordered, out_valid_q |-> (result_q.y_min <= result_q.y_max), "result min above max")
  `MMDD_ASSERT(a_frame_clears, (adv && item_i.frame_start) |=> (have_prev_q && !group_open_q), "frame start left a group open")
  `MMDD_ASSERT(a_emit_closes, (emit && go) |=> !group_open_q, "group still open after flush")

endmodule

// ===== rtl/core/minmax_display_decimator.sv =====
// ----------------------------------------------------------------------------
// minmax_display_decimator
// Min/max peak decimation of a waveform sample stream for display.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//  in        in_valid_i / in_ready_o    frame_start_i, x_pos_i, sample_i
//  out       out_valid_o / out_ready_i  point_x_o, y_max_o, y_min_o
//
//  One sample per cycle without stalls; a result is valid the cycle after its flush sample.
//  The 32x13 pixel-distance multiply and compare against the span set the path.
//  Reset clears the previous sample, the open group and the result valid flag.
//  An output stall holds the core; the input register takes one more request.
// ----------------------------------------------------------------------------
module minmax_display_decimator (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [mmdd_pkg::CFG_IDX_BITS-1:0]           cfg_index_i,
  input  logic [mmdd_pkg::CFG_DATA_BITS-1:0]          cfg_data_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic                                        frame_start_i,
  input  logic [mmdd_pkg::POS_BITS-1:0]               x_pos_i,
  input  logic signed [mmdd_pkg::SAMPLE_BITS-1:0]     sample_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [mmdd_pkg::POS_BITS-1:0]               point_x_o,
  output logic signed [mmdd_pkg::SAMPLE_BITS-1:0]     y_max_o,
  output logic signed [mmdd_pkg::SAMPLE_BITS-1:0]     y_min_o
);

  mmdd_pkg::cfg_t    cfg;
  mmdd_pkg::item_t   in_item, core_item;
  mmdd_pkg::result_t result;
  logic              core_valid, pop;

  assign in_item.frame_start = frame_start_i;
  assign in_item.x_pos       = x_pos_i;
  assign in_item.sample      = sample_i;

  mmdd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mmdd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .valid_o    (core_valid),
    .item_o     (core_item),
    .pop_i      (pop)
  );

  mmdd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (core_valid),
    .item_i      (core_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign point_x_o = result.point_x;
  assign y_max_o   = result.y_max;
  assign y_min_o   = result.y_min;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: min/max display decimator testbench
// Streams waveform samples through the decimator under random back-pressure
// and gaps, predicts every emitted point or min/max group in the testbench,
// and checks each point in order. View width and span are changed between
// phases while the block is idle, including zero and full-scale settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned END_WAIT        = 5000;
  localparam int unsigned RANDOM_PER_VIEW = 115;
  localparam int unsigned MAX_REPORTS     = 50;

  logic                                    clk_i;
  logic                                    rst_ni;
  logic                                    cfg_valid_i;
  logic                                    cfg_ready_o;
  logic [mmdd_pkg::CFG_IDX_BITS-1:0]       cfg_index_i;
  logic [mmdd_pkg::CFG_DATA_BITS-1:0]      cfg_data_i;
  logic                                    in_valid_i;
  logic                                    in_ready_o;
  logic                                    frame_start_i;
  logic [mmdd_pkg::POS_BITS-1:0]           x_pos_i;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] sample_i;
  logic                                    out_valid_o;
  logic                                    out_ready_i;
  logic [mmdd_pkg::POS_BITS-1:0]           point_x_o;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] y_max_o;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] y_min_o;

  minmax_display_decimator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_start_i (frame_start_i),
    .x_pos_i       (x_pos_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_x_o     (point_x_o),
    .y_max_o       (y_max_o),
    .y_min_o       (y_min_o)
  );

  // predicted decimator state
  mmdd_pkg::cfg_t                          view_cfg;
  logic                                    have_prev;
  logic [mmdd_pkg::POS_BITS-1:0]           prev_x;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] prev_y;
  logic                                    group_open;
  logic [mmdd_pkg::POS_BITS-1:0]           group_x;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] group_max;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] group_min;

  mmdd_pkg::result_t expected_points[$];

  int unsigned mismatch_count;
  int unsigned samples_sent;
  int unsigned points_checked;
  int unsigned views_set;
  int unsigned cycle_count;
  logic        idling_on;
  logic        hold_off_pending;

  logic [mmdd_pkg::POS_BITS-1:0]           gen_x;
  logic signed [mmdd_pkg::SAMPLE_BITS-1:0] gen_y;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void predict_decimation(mmdd_pkg::item_t s);
    logic                                    wide;
    logic [mmdd_pkg::POS_BITS-1:0]           dx;
    logic signed [mmdd_pkg::SAMPLE_BITS-1:0] y;
    mmdd_pkg::result_t                       pt;
    y = s.sample;
    if (s.frame_start) begin
      have_prev  = 1'b0;
      group_open = 1'b0;
    end
    if (have_prev) begin
      wide = 1'b0;
      if (s.x_pos >= prev_x) begin
        dx   = s.x_pos - prev_x;
        wide = (64'(dx) * 64'(view_cfg.view_width_px)) > 64'(view_cfg.view_span);
      end
      if (wide) begin
        if (group_open) begin
          pt = '{point_x: group_x, y_max: group_max, y_min: group_min};
          group_open = 1'b0;
        end else begin
          pt = '{point_x: prev_x, y_max: prev_y, y_min: prev_y};
        end
        expected_points.push_back(pt);
      end else if (!group_open) begin
        group_x    = prev_x;
        group_max  = (prev_y > y) ? prev_y : y;
        group_min  = (prev_y > y) ? y : prev_y;
        group_open = 1'b1;
      end else begin
        if (y > group_max) group_max = y;
        if (y < group_min) group_min = y;
      end
    end
    have_prev = 1'b1;
    prev_x    = s.x_pos;
    prev_y    = y;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_sample(logic fs, logic [mmdd_pkg::POS_BITS-1:0] x,
                             logic signed [mmdd_pkg::SAMPLE_BITS-1:0] y,
                             int unsigned gap);
    mmdd_pkg::item_t s;
    s = '{frame_start: fs, x_pos: x, sample: y};
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    frame_start_i <= s.frame_start;
    x_pos_i       <= s.x_pos;
    sample_i      <= s.sample;
    do @(posedge clk_i); while (!in_ready_o);
    predict_decimation(s);
    samples_sent++;
    gen_x = x;
    gen_y = y;
  endtask

  task automatic write_reg(logic [mmdd_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mmdd_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mmdd_pkg::CFG_VIEW_WIDTH)
      view_cfg.view_width_px = data[mmdd_pkg::WIDTH_BITS-1:0];
    else view_cfg.view_span = data[mmdd_pkg::SPAN_BITS-1:0];
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_view(logic [mmdd_pkg::WIDTH_BITS-1:0] w,
                          logic [mmdd_pkg::SPAN_BITS-1:0] s);
    logic [mmdd_pkg::CFG_DATA_BITS-1:0] d;
    wait_idle();
    d = $urandom;
    d[mmdd_pkg::WIDTH_BITS-1:0] = w;
    write_reg(mmdd_pkg::CFG_VIEW_WIDTH, d);
    write_reg(mmdd_pkg::CFG_VIEW_SPAN, s);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    views_set++;
  endtask

  // default view: one position unit per pixel, so dx >= 2 is wide
  task automatic test_first_sample_and_points();
    send_sample(1'b1, 32'd100, 16'sd5, 0);
    send_sample(1'b0, 32'd102, -16'sd3, 0);
    send_sample(1'b0, 32'd104, 16'sd7, 0);
  endtask

  task automatic test_grouping();
    send_sample(1'b0, 32'd105, 16'sh7FFF, 0);
    send_sample(1'b0, 32'd105, 16'sh8000, 0);
    send_sample(1'b0, 32'd105, 16'sh7FFF, 1);
    send_sample(1'b0, 32'd103, 16'sd0, 0);
    send_sample(1'b0, 32'd110, 16'sd1, 2);
    send_sample(1'b0, 32'd113, 16'sd2, 0);
  endtask

  task automatic test_frame_boundaries();
    send_sample(1'b0, 32'd114, 16'sd9, 0);
    send_sample(1'b1, 32'd0, -16'sd1, 0);
    send_sample(1'b0, 32'd1, 16'sd4, 0);
    send_sample(1'b1, 32'hFFFF_FFF0, 16'sh7FFF, 0);
    send_sample(1'b0, 32'hFFFF_FFFF, 16'sh8000, 0);
  endtask

  task automatic test_zero_width();
    set_view('0, 32'd1024);
    send_sample(1'b1, 32'd0, 16'sd3, 0);
    send_sample(1'b0, 32'hFFFF_FFFF, 16'sd4, 0);
    send_sample(1'b0, 32'd5, -16'sd4, 0);
  endtask

  task automatic test_zero_span();
    set_view(13'h1FFF, '0);
    send_sample(1'b1, 32'd7, 16'sd1, 0);
    send_sample(1'b0, 32'd7, 16'sd2, 0);
    send_sample(1'b0, 32'd8, 16'sd3, 0);
    send_sample(1'b0, 32'hFFFF_FFFF, 16'sh8000, 0);
  endtask

  task automatic test_full_scale_view();
    set_view(13'd4096, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'd0, 16'sd0, 0);
    send_sample(1'b0, 32'd1048575, 16'sd1, 0);
    send_sample(1'b0, 32'd2097151, 16'sd2, 0);
  endtask

  // every step is wide, so each sample after the first yields a point, with the output held off at the start
  task automatic test_output_hold_off();
    set_view(13'd4096, 32'd1);
    hold_off_pending = 1'b1;
    send_sample(1'b1, 32'd1000, mmdd_pkg::SAMPLE_BITS'($urandom), 0);
    for (int n = 0; n < 40; n++)
      send_sample(1'b0, gen_x + 32'd1, mmdd_pkg::SAMPLE_BITS'($urandom), 0);
  endtask

  task automatic run_random(int unsigned count);
    longint unsigned                         pixel;
    longint unsigned                         dx;
    logic [mmdd_pkg::POS_BITS-1:0]           xn;
    logic signed [mmdd_pkg::SAMPLE_BITS-1:0] y;
    logic                                    fs;
    int unsigned                             r;
    int unsigned                             gap;
    if (view_cfg.view_width_px == 0) pixel = 64'd1 << 20;
    else pixel = 64'(view_cfg.view_span) / 64'(view_cfg.view_width_px);
    for (int unsigned i = 0; i < count; i++) begin
      r  = $urandom_range(99, 0);
      fs = 1'b0;
      if (r < 4) begin
        fs = 1'b1;
        xn = $urandom;
      end else if (r < 10) begin
        xn = $urandom;
      end else begin
        case ($urandom_range(4, 0))
          0:       dx = 64'd0;
          1:       dx = pixel;
          2:       dx = pixel + 64'd1;
          3:       dx = 64'($urandom_range(32'(pixel), 0));
          default: dx = pixel + 64'd1 + 64'($urandom_range(32'(pixel), 0));
        endcase
        xn = gen_x + dx[mmdd_pkg::POS_BITS-1:0];
      end
      case ($urandom_range(9, 0))
        0:       y = 16'sh7FFF;
        1:       y = 16'sh8000;
        2:       y = gen_y;
        default: y = mmdd_pkg::SAMPLE_BITS'($urandom);
      endcase
      gap = (idling_on && $urandom_range(99, 0) < 30) ? pick_gap() : 0;
      send_sample(fs, xn, y, gap);
    end
  endtask

  task automatic test_random_views();
    logic [mmdd_pkg::WIDTH_BITS-1:0] w;
    logic [mmdd_pkg::SPAN_BITS-1:0]  s;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin w = 13'd1024;      s = 32'd1024;      end
        1: begin w = 13'd1;         s = 32'd1;         end
        2: begin w = 13'd4096;      s = 32'hFFFF_FFFF; end
        3: begin w = 13'h1FFF;      s = 32'hFFFF_FFFF; end
        4: begin w = 13'd1;         s = 32'hFFFF_FFFF; end
        5: begin w = '0;            s = $urandom;      end
        6: begin w = mmdd_pkg::WIDTH_BITS'($urandom); s = '0; end
        default: begin
          w = mmdd_pkg::WIDTH_BITS'($urandom_range(4096, 1));
          s = 32'($urandom) >> $urandom_range(31, 0);
        end
      endcase
      set_view(w, s);
      idling_on = (p % 3) != 2;
      run_random(RANDOM_PER_VIEW);
    end
  endtask

  initial begin : receiver
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready_i <= 1'b0;
        for (int unsigned n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (idling_on && $urandom_range(99, 0) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : point_checker
    mmdd_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point, point_x", point_x_o, 0);
      end else begin
        want = expected_points.pop_front();
        if (point_x_o !== want.point_x) report_mismatch("point_x", point_x_o, want.point_x);
        if (y_max_o !== want.y_max) report_mismatch("y_max", 16'(y_max_o), 16'(want.y_max));
        if (y_min_o !== want.y_min) report_mismatch("y_min", 16'(y_min_o), 16'(want.y_min));
        points_checked++;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    frame_start_i = 1'b0;
    x_pos_i       = '0;
    sample_i      = '0;
    idling_on        = 1'b1;
    hold_off_pending = 1'b0;
    mismatch_count = 0;
    samples_sent   = 0;
    points_checked = 0;
    views_set      = 0;
    gen_x = '0;
    gen_y = '0;
    view_cfg   = '{view_width_px: mmdd_pkg::VIEW_WIDTH_RST,
                   view_span: mmdd_pkg::VIEW_SPAN_RST};
    have_prev  = 1'b0;
    prev_x     = '0;
    prev_y     = '0;
    group_open = 1'b0;
    group_x    = '0;
    group_max  = '0;
    group_min  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_sample_and_points();
    test_grouping();
    test_frame_boundaries();
    test_zero_width();
    test_zero_span();
    test_full_scale_view();
    test_output_hold_off();
    test_random_views();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int unsigned n = 0; n < END_WAIT && expected_points.size() != 0; n++)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_points.size() != 0)
      report_mismatch("points never delivered, count", expected_points.size(), 0);

    $display("Streamed %0d samples across %0d view settings plus the reset view.",
             samples_sent, views_set);
    $display("Checked %0d decimated points, %0d mismatches.", points_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mmdd_pkg.sv
rtl/core/mmdd_cfg_regs.sv
rtl/core/mmdd_in_reg.sv
rtl/core/mmdd_core.sv
rtl/core/minmax_display_decimator.sv
dv/tb_top.sv
